@@ sv/mpbm_pkg.sv @@
package mpbm_pkg;

  // default sizes of the pattern table and the context space
  localparam int MAX_PATTERNS_DEF    = 16;
  localparam int MAX_PATTERN_LEN_DEF = 32;
  localparam int NUM_CONTEXTS_DEF    = 64;

  // payload field widths
  localparam int MODE_W  = 2;
  localparam int CTX_W   = 6;
  localparam int ADDR_W  = 64;
  localparam int BYTE_W  = 8;
  localparam int SLOT_W  = 4;
  localparam int POS_W   = 5;
  localparam int LEN_W   = 6;
  localparam int MASK_W  = 16;
  localparam int ACT_W   = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_SCAN     = 2'd0,
    MODE_PAT_BYTE = 2'd1,
    MODE_PAT_LEN  = 2'd2
  } mode_e;

  // pattern table write request, taken at the input handshake
  typedef struct packed {
    logic              byte_we;
    logic              len_we;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  pos;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  len;
  } pat_wr_t;

endpackage

@@ sv/mpbm_req_if.sv @@
interface mpbm_req_if;
  logic                        valid;
  logic                        ready;
  logic [mpbm_pkg::MODE_W-1:0] mode;
  logic [mpbm_pkg::CTX_W-1:0]  context_req;
  logic [mpbm_pkg::ADDR_W-1:0] byte_address;
  logic [mpbm_pkg::BYTE_W-1:0] data_byte;
  logic [mpbm_pkg::SLOT_W-1:0] slot;
  logic [mpbm_pkg::POS_W-1:0]  char_position;
  logic [mpbm_pkg::LEN_W-1:0]  pattern_length;

  modport source (
    output valid, mode, context_req, byte_address, data_byte, slot, char_position,
           pattern_length,
    input  ready
  );
  modport sink (
    input  valid, mode, context_req, byte_address, data_byte, slot, char_position,
           pattern_length,
    output ready
  );
endinterface

@@ sv/mpbm_res_if.sv @@
interface mpbm_res_if;
  logic                        valid;
  logic                        ready;
  logic [mpbm_pkg::CTX_W-1:0]  match_context;
  logic [mpbm_pkg::MASK_W-1:0] match_mask;
  logic [mpbm_pkg::ADDR_W-1:0] end_address;

  modport source (
    output valid, match_context, match_mask, end_address,
    input  ready
  );
  modport sink (
    input  valid, match_context, match_mask, end_address,
    output ready
  );
endinterface

@@ sv/mpbm_pattern_unit.sv @@
module mpbm_pattern_unit #(
  parameter int MAX_PATTERNS    = mpbm_pkg::MAX_PATTERNS_DEF,
  parameter int MAX_PATTERN_LEN = mpbm_pkg::MAX_PATTERN_LEN_DEF,
  localparam int CNT_W = $clog2(MAX_PATTERN_LEN + 1),
  localparam int ROW_W = MAX_PATTERNS * CNT_W
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mpbm_pkg::pat_wr_t           wr_i,
  input  logic [mpbm_pkg::ACT_W-1:0]  active_i,
  input  logic [mpbm_pkg::BYTE_W-1:0] scan_byte_i,
  input  logic [ROW_W-1:0]            cnt_i,
  output logic [ROW_W-1:0]            cnt_o,
  output logic [MAX_PATTERNS-1:0]     hit_o
);

  localparam int IDX_W = $clog2(MAX_PATTERN_LEN);

  logic [31:0]      len_clamp;
  logic [CNT_W-1:0] len_store;
  logic             pos_ok;

  // zero length stored as one, long lengths saturate
  assign len_clamp = (wr_i.len == '0) ? 32'd1 :
                     (32'(wr_i.len) > MAX_PATTERN_LEN) ? 32'(MAX_PATTERN_LEN) :
                     32'(wr_i.len);
  assign len_store = CNT_W'(len_clamp);
  assign pos_ok    = 32'(wr_i.pos) < MAX_PATTERN_LEN;

  for (genvar s = 0; s < MAX_PATTERNS; s++) begin : g_slot
    logic [mpbm_pkg::BYTE_W-1:0] pat_q [MAX_PATTERN_LEN];
    logic [CNT_W-1:0]            len_q;
    logic [CNT_W-1:0]            cnt;
    logic [CNT_W-1:0]            inc;
    logic                        sel;
    logic                        act;
    logic                        eq;
    logic                        done;

    assign sel = 32'(wr_i.slot) == s;

    always_ff @(posedge clk_i) begin
      if (wr_i.byte_we && sel && pos_ok) begin
        pat_q[IDX_W'(wr_i.pos)] <= wr_i.data;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        len_q <= CNT_W'(1);
      end else if (wr_i.len_we && sel) begin
        len_q <= len_store;
      end
    end

    assign cnt  = cnt_i[s*CNT_W +: CNT_W];
    assign act  = 32'(active_i) > s;
    // a counter past the end of the pattern table counts as a mismatch
    assign eq   = (32'(cnt) < MAX_PATTERN_LEN) && (pat_q[cnt[IDX_W-1:0]] == scan_byte_i);
    assign inc  = eq ? cnt + CNT_W'(1) : '0;
    assign done = inc == len_q;

    assign cnt_o[s*CNT_W +: CNT_W] = !act ? cnt : (done ? '0 : inc);
    assign hit_o[s]                = act && done;
  end

endmodule

@@ sv/multi_pattern_byte_matcher.sv @@
// Multi-pattern byte matcher: scan requests carry a byte, its address and a
// context; every active pattern slot advances its per-context progress counter
// in parallel, and a response with the mask of completed slots is sent when at
// least one pattern ends on that byte. Pattern byte and length writes travel on
// the same request channel and take effect for every later scan. One request is
// taken per cycle unless stalled; a scan passes stage one, then the response
// register. The per-context counters sit in one row-wide memory with a single
// read and a single write port; a scan reads its row when taken and writes it
// back on leaving stage one, with the new row forwarded to a same-context scan
// taken in that cycle. Each counter row has a valid flop cleared by reset, so
// no clearing pass follows reset. A held response stalls the channel once the
// stage behind it is also full. Pattern bytes read as garbage until written.
module multi_pattern_byte_matcher #(
  parameter int MAX_PATTERNS    = mpbm_pkg::MAX_PATTERNS_DEF,
  parameter int MAX_PATTERN_LEN = mpbm_pkg::MAX_PATTERN_LEN_DEF,
  parameter int NUM_CONTEXTS    = mpbm_pkg::NUM_CONTEXTS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mpbm_pkg::ACT_W-1:0] cfg_wdata_i,
  mpbm_req_if.sink                   req_i,
  mpbm_res_if.source                 res_o
);

  localparam int CNT_W = $clog2(MAX_PATTERN_LEN + 1);
  localparam int ROW_W = MAX_PATTERNS * CNT_W;
  localparam int IDX_W = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;

  logic [mpbm_pkg::ACT_W-1:0] active_q;

  logic                          req_acc;
  logic                          scan_acc;
  logic [IDX_W-1:0]              in_idx;
  mpbm_pkg::pat_wr_t             pat_wr;

  logic                          s1_vld_q, s1_vld_d;
  logic                          s1_move;
  logic [mpbm_pkg::CTX_W-1:0]    s1_ctx_q;
  logic [mpbm_pkg::ADDR_W-1:0]   s1_addr_q;
  logic [mpbm_pkg::BYTE_W-1:0]   s1_byte_q;
  logic [IDX_W-1:0]              s1_idx;

  logic [ROW_W-1:0]              cnt_mem [NUM_CONTEXTS];
  logic [NUM_CONTEXTS-1:0]       row_vld_q;
  logic [ROW_W-1:0]              rd_q;
  logic                          rv_q;
  logic                          fwd_q;
  logic [ROW_W-1:0]              fwd_row_q;
  logic [ROW_W-1:0]              cur_row;
  logic [ROW_W-1:0]              nxt_row;
  logic [MAX_PATTERNS-1:0]       hit;
  logic [mpbm_pkg::MASK_W-1:0]   mask;

  logic                          out_vld_q, out_vld_d;
  logic [mpbm_pkg::CTX_W-1:0]    out_ctx_q;
  logic [mpbm_pkg::MASK_W-1:0]   out_mask_q;
  logic [mpbm_pkg::ADDR_W-1:0]   out_addr_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (cfg_we_i) begin
      active_q <= cfg_wdata_i;
    end
  end

  // request side
  assign s1_move     = s1_vld_q && (!out_vld_q || res_o.ready);
  assign req_i.ready = !s1_vld_q || s1_move;
  assign req_acc     = req_i.valid && req_i.ready;
  assign scan_acc    = req_acc && (req_i.mode == mpbm_pkg::MODE_SCAN) &&
                       (32'(req_i.context_req) < NUM_CONTEXTS);
  assign in_idx      = IDX_W'(req_i.context_req);
  assign s1_idx      = IDX_W'(s1_ctx_q);

  always_comb begin
    pat_wr         = '0;
    pat_wr.byte_we = req_acc && (req_i.mode == mpbm_pkg::MODE_PAT_BYTE);
    pat_wr.len_we  = req_acc && (req_i.mode == mpbm_pkg::MODE_PAT_LEN);
    pat_wr.slot    = req_i.slot;
    pat_wr.pos     = req_i.char_position;
    pat_wr.data    = req_i.data_byte;
    pat_wr.len     = req_i.pattern_length;
  end

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (req_acc) begin
      s1_vld_d = scan_acc;
    end else if (s1_move) begin
      s1_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      row_vld_q <= '0;
      rv_q      <= 1'b0;
      fwd_q     <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
      if (s1_move) begin
        row_vld_q[s1_idx] <= 1'b1;
      end
      if (scan_acc) begin
        rv_q  <= row_vld_q[in_idx];
        // row still being written back this edge
        fwd_q <= s1_move && (s1_ctx_q == req_i.context_req);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      cnt_mem[s1_idx] <= nxt_row;
    end
    if (scan_acc) begin
      rd_q      <= cnt_mem[in_idx];
      fwd_row_q <= nxt_row;
      s1_ctx_q  <= req_i.context_req;
      s1_addr_q <= req_i.byte_address;
      s1_byte_q <= req_i.data_byte;
    end
  end

  assign cur_row = fwd_q ? fwd_row_q : (rv_q ? rd_q : '0);

  mpbm_pattern_unit #(
    .MAX_PATTERNS    (MAX_PATTERNS),
    .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
  ) u_pattern (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (pat_wr),
    .active_i    (active_q),
    .scan_byte_i (s1_byte_q),
    .cnt_i       (cur_row),
    .cnt_o       (nxt_row),
    .hit_o       (hit)
  );

  // only the low slots are visible in the mask
  for (genvar b = 0; b < mpbm_pkg::MASK_W; b++) begin : g_mask
    if (b < MAX_PATTERNS) begin : g_on
      assign mask[b] = hit[b];
    end else begin : g_off
      assign mask[b] = 1'b0;
    end
  end

  // response register
  always_comb begin
    out_vld_d = out_vld_q;
    if (s1_move) begin
      out_vld_d = mask != '0;
    end else if (res_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move && (mask != '0)) begin
      out_ctx_q  <= s1_ctx_q;
      out_mask_q <= mask;
      out_addr_q <= s1_addr_q;
    end
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.match_context = out_ctx_q;
  assign res_o.match_mask    = out_mask_q;
  assign res_o.end_address   = out_addr_q;

  a_no_empty_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_mask_q != '0))
    else $error("response with empty match mask");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && out_vld_q && !res_o.ready) |-> !req_i.ready)
    else $error("request taken while pipeline is blocked");

  a_fwd_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fwd_q && $past(scan_acc)) |-> $past(s1_move))
    else $error("forwarded row without a write-back");

  a_row_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> row_vld_q[$past(s1_idx)])
    else $error("written counter row not marked valid");

  a_res_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(s1_move))
    else $error("response without a scan behind it");

endmodule

@@ tb/sv/tb_multi_pattern_byte_matcher.sv @@
`timescale 1ns / 1ps

module tb_multi_pattern_byte_matcher;

  typedef logic [mpbm_pkg::MODE_W-1:0] mode_t;
  typedef logic [mpbm_pkg::CTX_W-1:0]  ctx_t;
  typedef logic [mpbm_pkg::ADDR_W-1:0] addr_t;
  typedef logic [mpbm_pkg::BYTE_W-1:0] byte_t;
  typedef logic [mpbm_pkg::SLOT_W-1:0] slot_t;
  typedef logic [mpbm_pkg::POS_W-1:0]  pos_t;
  typedef logic [mpbm_pkg::LEN_W-1:0]  len_t;
  typedef logic [mpbm_pkg::MASK_W-1:0] mask_t;
  typedef logic [mpbm_pkg::ACT_W-1:0]  act_t;

  localparam int NUM_SLOTS = mpbm_pkg::MAX_PATTERNS_DEF;
  localparam int PAT_LEN_MAX = mpbm_pkg::MAX_PATTERN_LEN_DEF;
  localparam int NUM_CTX = mpbm_pkg::NUM_CONTEXTS_DEF;
  localparam mode_t MODE_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 5000;
  localparam int LONG_HOLD = 400;
  localparam int DRAIN_CYCLES = 10;
  localparam int RANDOM_PER_PHASE = 80;
  localparam int NUM_PHASES = 6;

  typedef struct packed {
    mode_t mode;
    ctx_t  ctx;
    addr_t addr;
    byte_t data;
    slot_t slot;
    pos_t  pos;
    len_t  len;
  } scan_req_t;

  typedef struct packed {
    ctx_t  ctx;
    mask_t mask;
    addr_t addr;
  } match_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_style_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we;
  act_t cfg_wdata;

  mpbm_req_if req_if ();
  mpbm_res_if res_if ();

  multi_pattern_byte_matcher i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .res_o       (res_if)
  );

  always #10 clk_i = ~clk_i;

  // matcher state as the block should hold it
  len_t  progress [NUM_CTX][NUM_SLOTS];
  byte_t pat_byte [NUM_SLOTS][PAT_LEN_MAX];
  len_t  pat_len [NUM_SLOTS];
  act_t  active_cfg;

  // pattern table as queued, used to build matching byte runs
  byte_t gen_byte [NUM_SLOTS][PAT_LEN_MAX];
  len_t  gen_len [NUM_SLOTS];

  scan_req_t pending_reqs[$];
  match_t    expected_matches[$];
  scan_req_t in_flight;

  int fail_count = 0;
  int reqs_taken = 0;
  int scans_taken = 0;
  int matches_seen = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int rx_cycle = 0;
  int hold_left = 0;
  bit long_hold_arm = 1'b0;
  bit long_hold_done = 1'b0;
  rx_style_e rx_style = RX_OPEN;

  function automatic len_t stored_len(input len_t len);
    if (len == 0) return len_t'(1);
    if (len > PAT_LEN_MAX) return len_t'(PAT_LEN_MAX);
    return len;
  endfunction

  function automatic void apply_request(input scan_req_t r);
    int n;
    len_t  c;
    mask_t mask;
    case (r.mode)
      mpbm_pkg::MODE_PAT_BYTE: pat_byte[r.slot][r.pos] = r.data;
      mpbm_pkg::MODE_PAT_LEN: pat_len[r.slot] = stored_len(r.len);
      mpbm_pkg::MODE_SCAN: begin
        n = (active_cfg > NUM_SLOTS) ? NUM_SLOTS : int'(active_cfg);
        mask = '0;
        for (int s = 0; s < n; s++) begin
          c = progress[r.ctx][s];
          // a counter past the end of the table never matches
          if (c < PAT_LEN_MAX && pat_byte[s][c[mpbm_pkg::POS_W-1:0]] == r.data) c = c + 1'b1;
          else c = '0;
          if (c == pat_len[s]) begin
            c = '0;
            mask[s] = 1'b1;
          end
          progress[r.ctx][s] = c;
        end
        if (mask != 0) expected_matches.push_back('{ctx: r.ctx, mask: mask, addr: r.addr});
      end
      default: ;
    endcase
  endfunction

  function automatic byte_t alpha();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h3C;
      default: return 8'hC3;
    endcase
  endfunction

  function automatic len_t rand_len();
    case ($urandom_range(0, 9))
      0: return len_t'(0);
      1: return len_t'($urandom_range(PAT_LEN_MAX + 1, 63));
      2: return len_t'($urandom_range(7, PAT_LEN_MAX));
      default: return len_t'($urandom_range(1, 6));
    endcase
  endfunction

  // unused fields of a request still carry random bits
  function automatic scan_req_t rand_fields();
    scan_req_t r;
    r.mode = mpbm_pkg::MODE_SCAN;
    r.ctx  = ctx_t'($urandom_range(0, NUM_CTX - 1));
    r.addr = {$urandom, $urandom};
    r.data = byte_t'($urandom_range(0, 255));
    r.slot = slot_t'($urandom_range(0, NUM_SLOTS - 1));
    r.pos  = pos_t'($urandom_range(0, PAT_LEN_MAX - 1));
    r.len  = len_t'($urandom_range(0, 63));
    return r;
  endfunction

  function automatic void push_scan(input ctx_t ctx, input addr_t addr, input byte_t data);
    scan_req_t r;
    r = rand_fields();
    r.ctx = ctx;
    r.addr = addr;
    r.data = data;
    pending_reqs.push_back(r);
  endfunction

  function automatic void push_byte_write(input int slot, input int pos, input byte_t data);
    scan_req_t r;
    r = rand_fields();
    r.mode = mpbm_pkg::MODE_PAT_BYTE;
    r.slot = slot_t'(slot);
    r.pos = pos_t'(pos);
    r.data = data;
    gen_byte[slot][pos] = data;
    pending_reqs.push_back(r);
  endfunction

  function automatic void push_len_write(input int slot, input len_t len);
    scan_req_t r;
    r = rand_fields();
    r.mode = mpbm_pkg::MODE_PAT_LEN;
    r.slot = slot_t'(slot);
    r.len = len;
    gen_len[slot] = stored_len(len);
    pending_reqs.push_back(r);
  endfunction

  function automatic void push_unused();
    scan_req_t r;
    r = rand_fields();
    r.mode = MODE_UNUSED;
    pending_reqs.push_back(r);
  endfunction

  // feeds the first n bytes of a slot's pattern, optionally with one byte spoiled
  function automatic void push_pattern_run(input int slot, input int ctx, input int n,
                                           input bit corrupt);
    addr_t base;
    byte_t d;
    int bad;
    base = {$urandom, $urandom};
    bad = corrupt ? int'($urandom_range(0, n - 1)) : -1;
    for (int i = 0; i < n; i++) begin
      d = gen_byte[slot][i];
      if (i == bad) d = d ^ byte_t'($urandom_range(1, 255));
      push_scan(ctx_t'(ctx), base + addr_t'(i), d);
    end
  endfunction

  task automatic random_phase(input int count);
    int made;
    int pick;
    int n_act;
    int s;
    n_act = (active_cfg > NUM_SLOTS) ? NUM_SLOTS : int'(active_cfg);
    made = 0;
    while (made < count) begin
      pick = int'($urandom_range(0, 99));
      if (pick < 55 && n_act > 0) begin
        s = int'($urandom_range(0, n_act - 1));
        push_pattern_run(s, int'($urandom_range(0, NUM_CTX - 1)), int'(gen_len[s]),
                         $urandom_range(0, 4) == 0);
        made += int'(gen_len[s]);
      end else if (pick < 70) begin
        push_byte_write(int'($urandom_range(0, NUM_SLOTS - 1)),
                        int'($urandom_range(0, PAT_LEN_MAX - 1)),
                        ($urandom_range(0, 3) == 0) ? byte_t'($urandom_range(0, 255)) : alpha());
        made++;
      end else if (pick < 76) begin
        push_len_write(int'($urandom_range(0, NUM_SLOTS - 1)), rand_len());
        made++;
      end else if (pick < 95) begin
        push_scan(ctx_t'($urandom_range(0, NUM_CTX - 1)), {$urandom, $urandom},
                  ($urandom_range(0, 1) == 0) ? byte_t'($urandom_range(0, 255)) : alpha());
        made++;
      end else begin
        push_unused();
        made++;
      end
    end
  endtask

  task automatic wait_quiet();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || req_if.valid || expected_matches.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_active(input act_t v);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    active_cfg = v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // request driver, bursts of random length with random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        apply_request(in_flight);
        reqs_taken++;
        if (in_flight.mode == mpbm_pkg::MODE_SCAN) scans_taken++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          in_flight = pending_reqs.pop_front();
          req_if.mode <= in_flight.mode;
          req_if.context_req <= in_flight.ctx;
          req_if.byte_address <= in_flight.addr;
          req_if.data_byte <= in_flight.data;
          req_if.slot <= in_flight.slot;
          req_if.char_position <= in_flight.pos;
          req_if.pattern_length <= in_flight.len;
          req_if.valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // response ready pattern, plus one long hold-off to back up the pipeline
  always @(posedge clk_i) begin
    if (rst_ni) begin
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_style = rx_style_e'($urandom_range(0, 3));
      if (long_hold_arm && !long_hold_done) begin
        hold_left = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        case (rx_style)
          RX_OPEN: res_if.ready <= 1'b1;
          RX_COIN: res_if.ready <= ($urandom_range(0, 1) == 1);
          RX_SPARSE: res_if.ready <= (rx_cycle % 4 == 0);
          default: res_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 100)
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endfunction

  // response monitor and idle counter
  always @(posedge clk_i) begin
    match_t want;
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (rst_ni && res_if.valid && res_if.ready) begin
      matches_seen++;
      if (expected_matches.size() == 0) begin
        fail_count++;
        if (fail_count <= 100)
          $display("%0t: unexpected response, expected none, got ctx %0d mask %h addr %h",
                   $time, res_if.match_context, res_if.match_mask, res_if.end_address);
      end else begin
        want = expected_matches.pop_front();
        check_field("match_context", 64'(want.ctx), 64'(res_if.match_context));
        check_field("match_mask", 64'(want.mask), 64'(res_if.match_mask));
        check_field("end_address", want.addr, res_if.end_address);
      end
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("%0t: nothing accepted for %0d cycles", $time, IDLE_LIMIT);
    $display("multi_pattern_byte_matcher regression: fail");
    $finish;
  end

  initial begin
    act_t phase_cfg [NUM_PHASES];
    int deep_ctx;

    req_if.valid = 1'b0;
    req_if.mode = '0;
    req_if.context_req = '0;
    req_if.byte_address = '0;
    req_if.data_byte = '0;
    req_if.slot = '0;
    req_if.char_position = '0;
    req_if.pattern_length = '0;
    res_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    active_cfg = '0;
    for (int c = 0; c < NUM_CTX; c++)
      for (int s = 0; s < NUM_SLOTS; s++) progress[c][s] = '0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      pat_len[s] = len_t'(1);
      gen_len[s] = len_t'(1);
      for (int p = 0; p < PAT_LEN_MAX; p++) begin
        pat_byte[s][p] = '0;
        gen_byte[s][p] = '0;
      end
    end

    phase_cfg[0] = act_t'(NUM_SLOTS);
    phase_cfg[1] = act_t'(1);
    phase_cfg[2] = act_t'(31);
    phase_cfg[3] = act_t'(NUM_SLOTS + 1);
    phase_cfg[4] = act_t'($urandom_range(2, NUM_SLOTS - 1));
    phase_cfg[5] = act_t'(NUM_SLOTS);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_active(act_t'(0));

    // load every pattern byte before any slot is active, so no unwritten byte is read
    for (int s = 0; s < NUM_SLOTS; s++)
      for (int p = 0; p < PAT_LEN_MAX; p++) push_byte_write(s, p, alpha());
    for (int s = 0; s < NUM_SLOTS; s++) push_len_write(s, len_t'((s % 4) + 1));
    // no slot active: scans give nothing
    repeat (3) push_scan(ctx_t'($urandom_range(0, NUM_CTX - 1)), {$urandom, $urandom}, alpha());
    wait_quiet();

    set_active(phase_cfg[0]);
    push_len_write(0, len_t'(0));
    push_len_write(1, len_t'(63));
    push_len_write(2, len_t'(PAT_LEN_MAX));
    push_scan(ctx_t'(0), '0, gen_byte[0][0]);
    push_scan(ctx_t'(NUM_CTX - 1), '1, 8'hFF);
    push_scan(ctx_t'(NUM_CTX - 1), '1, 8'h00);
    push_unused();
    push_byte_write(NUM_SLOTS - 1, PAT_LEN_MAX - 1, 8'hFF);
    push_byte_write(NUM_SLOTS - 1, 0, 8'h00);
    push_len_write(NUM_SLOTS - 1, len_t'(1));
    push_scan(ctx_t'(9), {$urandom, $urandom}, 8'h00);
    push_pattern_run(3, 5, int'(gen_len[3]), 1'b0);
    // a mismatch drops the counter to zero without retrying the byte
    push_pattern_run(3, 6, 2, 1'b0);
    push_scan(ctx_t'(6), {$urandom, $urandom}, gen_byte[3][2] ^ 8'h80);
    push_pattern_run(3, 6, int'(gen_len[3]), 1'b0);
    push_len_write(1, len_t'(2));
    push_pattern_run(1, 12, 2, 1'b0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) set_active(phase_cfg[ph]);
      random_phase(RANDOM_PER_PHASE);
      if (ph == 0) begin
        @(posedge clk_i);
        long_hold_arm <= 1'b1;
      end
      if (ph == NUM_PHASES - 1) begin
        // push a counter past the pattern end by shortening the length mid-match
        deep_ctx = int'($urandom_range(0, NUM_CTX - 1));
        push_len_write(0, len_t'(PAT_LEN_MAX));
        push_pattern_run(0, deep_ctx, PAT_LEN_MAX - 1, 1'b0);
        push_len_write(0, len_t'($urandom_range(1, 8)));
        push_scan(ctx_t'(deep_ctx), {$urandom, $urandom}, gen_byte[0][PAT_LEN_MAX - 1]);
        push_scan(ctx_t'(deep_ctx), {$urandom, $urandom}, gen_byte[0][0]);
        push_scan(ctx_t'(deep_ctx), {$urandom, $urandom}, gen_byte[0][0]);
      end
      wait_quiet();
    end

    $display("run covered %0d requests, %0d of them scans, with %0d match responses checked",
             reqs_taken, scans_taken, matches_seen);
    $display("active slot settings 0, 16, 1, 31, 17 and %0d; lengths 0 to 63; long output stall",
             phase_cfg[4]);
    if (fail_count == 0) begin
      $display("multi_pattern_byte_matcher regression: pass");
    end else begin
      $display("multi_pattern_byte_matcher regression: fail");
    end
    $finish;
  end

endmodule

@@ multi_pattern_byte_matcher.f @@
sv/mpbm_pkg.sv
sv/mpbm_req_if.sv
sv/mpbm_res_if.sv
sv/mpbm_pattern_unit.sv
sv/multi_pattern_byte_matcher.sv
tb/sv/tb_multi_pattern_byte_matcher.sv
